FILE: sv/stunp_pkg.sv
// ============================================================================
// STUN parser package
// Shared constants, field codes and the token that passes from the front
// part of the parser to the back part.
// ============================================================================
package stunp_pkg;

    // Fixed field widths of the message layout.
    localparam int OFFSET_BITS = 17;
    localparam int LENGTH_BITS = 16;
    localparam int TYPE_BITS   = 16;

    // Default width of the saturating byte position counter.
    localparam int POSITION_BITS_DEFAULT = 17;

    // Depth of the queue between the front and back parts.
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    // Header layout and well-known codes.
    localparam logic [OFFSET_BITS-1:0] HEADER_BYTES            = 17'd20;
    localparam logic [31:0]            MAGIC_COOKIE            = 32'h2112_A442;
    localparam logic [TYPE_BITS-1:0]   TYPE_BINDING_REQUEST    = 16'h0001;
    localparam logic [TYPE_BITS-1:0]   TYPE_BINDING_INDICATION = 16'h0011;
    localparam logic [TYPE_BITS-1:0]   WANTED_TYPE_RESET       = 16'h0006;

    // Header byte boundaries used to classify a byte by its position.
    localparam int TYPE_END   = 2;
    localparam int LENGTH_END = 4;
    localparam int COOKIE_END = 8;
    localparam int TIDH_END   = 12;
    localparam int TIDL_END   = 20;

    // Which part of the datagram a byte belongs to.
    typedef enum logic [2:0] {
        FIELD_TYPE,
        FIELD_LENGTH,
        FIELD_COOKIE,
        FIELD_TID_HIGH,
        FIELD_TID_LOW,
        FIELD_BODY
    } field_t;

    // Classified byte handed from the front to the back.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
        field_t     field;
    } token_t;

    localparam int TOKEN_BITS = $bits(token_t);

endpackage

FILE: sv/stunp_if.sv
// ============================================================================
// STUN parser channel interfaces
// Valid/ready channels for the incoming byte stream and the parse result.
// ============================================================================
interface stunp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, output data_byte, output last, input ready);
    modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface stunp_out_if;
    logic        valid;
    logic        ready;
    logic        header_complete;
    logic [15:0] message_type;
    logic        is_binding_request;
    logic        is_binding_indication;
    logic [31:0] tid_high;
    logic [63:0] tid_low;
    logic        found;
    logic [16:0] value_offset;
    logic [15:0] value_length;

    modport source (
        output valid, output header_complete, output message_type,
        output is_binding_request, output is_binding_indication,
        output tid_high, output tid_low, output found,
        output value_offset, output value_length,
        input  ready
    );
    modport sink (
        input  valid, input header_complete, input message_type,
        input  is_binding_request, input is_binding_indication,
        input  tid_high, input tid_low, input found,
        input  value_offset, input value_length,
        output ready
    );
endinterface

FILE: sv/stunp_queue.sv
// ============================================================================
// STUN parser token queue
// Small register FIFO that decouples the front part from the back part.
// ============================================================================
module stunp_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             rd_valid
);

    localparam int PTR_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_BITS = $clog2(DEPTH + 1);
    localparam logic [PTR_BITS-1:0]   PTR_LAST  = PTR_BITS'(DEPTH - 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = COUNT_BITS'(DEPTH);

    logic [WIDTH-1:0]      slot_reg [DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic                  do_wr;
    logic                  do_rd;

    assign full     = (count_reg == COUNT_MAX);
    assign rd_valid = (count_reg != '0);
    assign rd_data  = slot_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    // Pointer wrap and occupancy.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage slots.
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: sv/stunp_front.sv
// ============================================================================
// STUN parser front part
// Accepts datagram bytes, tracks the saturating byte position and tags each
// byte with the header field or body region it belongs to.
// ============================================================================
module stunp_front #(
    parameter int POSITION_BITS = stunp_pkg::POSITION_BITS_DEFAULT
) (
    input  logic                     clk,
    input  logic                     rst_n,
    stunp_in_if.sink                 in_ch,
    input  logic                     queue_full,
    output logic                     push,
    output stunp_pkg::token_t        push_token,
    output logic [POSITION_BITS-1:0] push_position
);

    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    stunp_pkg::field_t        field;

    assign in_ch.ready = !queue_full;
    assign push        = in_ch.valid && !queue_full;

    // Classify the byte by its place in the datagram.
    always_comb
    begin
        priority if (pos_reg < POSITION_BITS'(stunp_pkg::TYPE_END))
        begin
            field = stunp_pkg::FIELD_TYPE;
        end
        else if (pos_reg < POSITION_BITS'(stunp_pkg::LENGTH_END))
        begin
            field = stunp_pkg::FIELD_LENGTH;
        end
        else if (pos_reg < POSITION_BITS'(stunp_pkg::COOKIE_END))
        begin
            field = stunp_pkg::FIELD_COOKIE;
        end
        else if (pos_reg < POSITION_BITS'(stunp_pkg::TIDH_END))
        begin
            field = stunp_pkg::FIELD_TID_HIGH;
        end
        else if (pos_reg < POSITION_BITS'(stunp_pkg::TIDL_END))
        begin
            field = stunp_pkg::FIELD_TID_LOW;
        end
        else
        begin
            field = stunp_pkg::FIELD_BODY;
        end
    end

    always_comb
    begin
        push_token.data_byte = in_ch.data_byte;
        push_token.last      = in_ch.last;
        push_token.field     = field;
        push_position        = pos_reg;
    end

    // The position restarts after the last byte and saturates otherwise.
    always_comb
    begin
        pos_next = pos_reg;
        if (push)
        begin
            if (in_ch.last)
            begin
                pos_next = '0;
            end
            else if (pos_reg != POS_MAX)
            begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

endmodule

FILE: sv/stunp_back.sv
// ============================================================================
// STUN parser back part
// Captures the header fields, walks the attributes inside the declared
// length and registers one result on the last byte of each datagram.
// ============================================================================
module stunp_back #(
    parameter int POSITION_BITS = stunp_pkg::POSITION_BITS_DEFAULT
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [15:0]              cfg_wdata,
    input  logic                     tok_valid,
    input  stunp_pkg::token_t        tok,
    input  logic [POSITION_BITS-1:0] tok_position,
    output logic                     pop,
    stunp_out_if.source              out_ch
);

    localparam int OB = stunp_pkg::OFFSET_BITS;
    localparam int LB = stunp_pkg::LENGTH_BITS;

    // Configuration and per-datagram state.
    logic [15:0]   wanted_type_reg;
    logic [15:0]   type_reg, type_next;
    logic [LB-1:0] len_reg, len_next;
    logic [31:0]   cookie_reg, cookie_next;
    logic [31:0]   tidh_reg, tidh_next;
    logic [63:0]   tidl_reg, tidl_next;
    logic [OB-1:0] next_off_reg, next_off_next;
    logic [31:0]   shift_reg, shift_next;
    logic          walk_done_reg, walk_done_next;
    logic          match_reg, match_next;
    logic [OB-1:0] match_off_reg, match_off_next;
    logic [LB-1:0] match_len_reg, match_len_next;

    // Output register.
    logic          out_valid_reg;
    logic          complete_reg;
    logic [15:0]   out_type_reg;
    logic          is_req_reg;
    logic          is_ind_reg;
    logic [31:0]   out_tidh_reg;
    logic [63:0]   out_tidl_reg;
    logic          found_reg;
    logic [OB-1:0] out_off_reg;
    logic [LB-1:0] out_len_reg;

    // Attribute walk arithmetic.
    logic [31:0]   shifted;
    logic [LB-1:0] val_len;
    logic [15:0]   attr_type;
    logic [OB-1:0] hdr_last;
    logic [OB:0]   hdr_end;
    logic [OB:0]   val_end;
    logic [OB:0]   msg_end;
    logic [OB-1:0] len_pad3;
    logic [OB-1:0] pad_len;
    logic          in_hdr;
    logic          at_hdr_last;
    logic          body_live;

    // Result terms.
    logic          complete;
    logic          cookie_ok;
    logic          found;
    logic [OB-1:0] need_last;

    // A result waits in the output register; a byte that creates one is only
    // taken when that register is free or being drained.
    assign pop = tok_valid && (!tok.last || !out_valid_reg || out_ch.ready);

    assign shifted     = {shift_reg[23:0], tok.data_byte};
    assign attr_type   = shifted[31:16];
    assign val_len     = shifted[15:0];
    assign hdr_last    = next_off_reg + OB'(3);
    assign hdr_end     = {1'b0, next_off_reg} + (OB+1)'(4);
    assign val_end     = hdr_end + {1'b0, OB'(val_len)};
    assign msg_end     = {1'b0, stunp_pkg::HEADER_BYTES} + {1'b0, OB'(len_reg)};
    assign len_pad3    = OB'(val_len) + OB'(3);
    assign pad_len     = {len_pad3[OB-1:2], 2'b00};
    assign body_live   = (tok.field == stunp_pkg::FIELD_BODY) && !walk_done_reg;
    assign in_hdr      = (tok_position >= POSITION_BITS'(next_off_reg))
                         && (tok_position <= POSITION_BITS'(hdr_last));
    assign at_hdr_last = (tok_position == POSITION_BITS'(hdr_last));

    // Next state for one byte.
    always_comb
    begin
        type_next      = type_reg;
        len_next       = len_reg;
        cookie_next    = cookie_reg;
        tidh_next      = tidh_reg;
        tidl_next      = tidl_reg;
        next_off_next  = next_off_reg;
        shift_next     = shift_reg;
        walk_done_next = walk_done_reg;
        match_next     = match_reg;
        match_off_next = match_off_reg;
        match_len_next = match_len_reg;
        unique case (tok.field)
            stunp_pkg::FIELD_TYPE:     type_next   = {type_reg[7:0], tok.data_byte};
            stunp_pkg::FIELD_LENGTH:   len_next    = {len_reg[7:0], tok.data_byte};
            stunp_pkg::FIELD_COOKIE:   cookie_next = {cookie_reg[23:0], tok.data_byte};
            stunp_pkg::FIELD_TID_HIGH: tidh_next   = {tidh_reg[23:0], tok.data_byte};
            stunp_pkg::FIELD_TID_LOW:  tidl_next   = {tidl_reg[55:0], tok.data_byte};
            stunp_pkg::FIELD_BODY:
            begin
                if (body_live && in_hdr)
                begin
                    shift_next = shifted;
                end
                if (body_live && at_hdr_last)
                begin
                    if ((hdr_end > msg_end) || (val_end > msg_end))
                    begin
                        walk_done_next = 1'b1;
                    end
                    else if (attr_type == wanted_type_reg)
                    begin
                        walk_done_next = 1'b1;
                        match_next     = 1'b1;
                        match_off_next = hdr_end[OB-1:0];
                        match_len_next = val_len;
                    end
                    else
                    begin
                        next_off_next = hdr_end[OB-1:0] + pad_len;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Result terms from the state that includes the last byte.
    assign need_last = OB'(stunp_pkg::TIDL_END - 1) + OB'(len_next);
    assign complete  = (tok_position >= POSITION_BITS'(stunp_pkg::TIDL_END - 1))
                       && (POSITION_BITS'(need_last) <= tok_position);
    assign cookie_ok = (cookie_next == stunp_pkg::MAGIC_COOKIE);
    assign found     = complete && match_next;

    // Per-datagram state and configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wanted_type_reg <= stunp_pkg::WANTED_TYPE_RESET;
            type_reg        <= '0;
            len_reg         <= '0;
            cookie_reg      <= '0;
            tidh_reg        <= '0;
            tidl_reg        <= '0;
            next_off_reg    <= stunp_pkg::HEADER_BYTES;
            shift_reg       <= '0;
            walk_done_reg   <= 1'b0;
            match_reg       <= 1'b0;
            match_off_reg   <= '0;
            match_len_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                wanted_type_reg <= cfg_wdata;
            end
            if (pop && tok.last)
            begin
                type_reg      <= '0;
                len_reg       <= '0;
                cookie_reg    <= '0;
                tidh_reg      <= '0;
                tidl_reg      <= '0;
                next_off_reg  <= stunp_pkg::HEADER_BYTES;
                shift_reg     <= '0;
                walk_done_reg <= 1'b0;
                match_reg     <= 1'b0;
                match_off_reg <= '0;
                match_len_reg <= '0;
            end
            else if (pop)
            begin
                type_reg      <= type_next;
                len_reg       <= len_next;
                cookie_reg    <= cookie_next;
                tidh_reg      <= tidh_next;
                tidl_reg      <= tidl_next;
                next_off_reg  <= next_off_next;
                shift_reg     <= shift_next;
                walk_done_reg <= walk_done_next;
                match_reg     <= match_next;
                match_off_reg <= match_off_next;
                match_len_reg <= match_len_next;
            end
        end
    end

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop && tok.last)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (pop && tok.last)
        begin
            complete_reg <= complete;
            out_type_reg <= type_next;
            is_req_reg   <= complete && cookie_ok
                            && (type_next == stunp_pkg::TYPE_BINDING_REQUEST);
            is_ind_reg   <= complete && cookie_ok
                            && (type_next == stunp_pkg::TYPE_BINDING_INDICATION);
            out_tidh_reg <= tidh_next;
            out_tidl_reg <= tidl_next;
            found_reg    <= found;
            out_off_reg  <= found ? match_off_next : '0;
            out_len_reg  <= found ? match_len_next : '0;
        end
    end

    assign out_ch.valid                 = out_valid_reg;
    assign out_ch.header_complete       = complete_reg;
    assign out_ch.message_type          = out_type_reg;
    assign out_ch.is_binding_request    = is_req_reg;
    assign out_ch.is_binding_indication = is_ind_reg;
    assign out_ch.tid_high              = out_tidh_reg;
    assign out_ch.tid_low               = out_tidl_reg;
    assign out_ch.found                 = found_reg;
    assign out_ch.value_offset          = out_off_reg;
    assign out_ch.value_length          = out_len_reg;

endmodule

FILE: sv/stun_header_attribute_parser.sv
// ============================================================================
// STUN header and attribute parser
// Parses a received datagram byte by byte and reports the header summary and
// the first attribute of the configured type.
// ============================================================================
// The parser takes one byte per clock while the queue has room, with no gaps
// between datagrams. A front part counts byte positions and classifies each
// byte; a two-entry queue hands the bytes to a back part that captures the
// header and walks the attributes. The result for a datagram is registered
// in the output register when the back part takes its last byte, and it
// waits there while the next datagram keeps streaming in; the back part
// waits on the last byte of a second datagram until the first result has
// been taken, and the input stalls once the queue behind it fills.
// The searched attribute type is set through cfg_we and cfg_wdata.
module stun_header_attribute_parser #(
    parameter int POSITION_BITS = stunp_pkg::POSITION_BITS_DEFAULT,
    parameter int QUEUE_DEPTH   = stunp_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    stunp_in_if.sink    in_ch,
    stunp_out_if.source out_ch
);

    localparam int QW = stunp_pkg::TOKEN_BITS + POSITION_BITS;

    logic                     queue_full;
    logic                     push;
    stunp_pkg::token_t        push_token;
    logic [POSITION_BITS-1:0] push_position;
    logic                     pop;
    logic                     tok_valid;
    logic [QW-1:0]            rd_data;
    stunp_pkg::token_t        tok;
    logic [POSITION_BITS-1:0] tok_position;

    // Byte intake and classification.
    stunp_front #(
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_ch         (in_ch),
        .queue_full    (queue_full),
        .push          (push),
        .push_token    (push_token),
        .push_position (push_position)
    );

    // Queue between the two parts.
    stunp_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (push),
        .wr_data  ({push_token, push_position}),
        .full     (queue_full),
        .rd_en    (pop),
        .rd_data  (rd_data),
        .rd_valid (tok_valid)
    );

    assign tok          = stunp_pkg::token_t'(rd_data[QW-1:POSITION_BITS]);
    assign tok_position = rd_data[POSITION_BITS-1:0];

    // Header capture, attribute walk and result register.
    stunp_back #(
        .POSITION_BITS (POSITION_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .tok_valid    (tok_valid),
        .tok          (tok),
        .tok_position (tok_position),
        .pop          (pop),
        .out_ch       (out_ch)
    );

endmodule

FILE: tb/stunp_result_checker.sv
// ============================================================================
// STUN parser result checker
// Watches the byte stream, the configuration port and the result channel of
// the parser. It keeps its own copy of the parse state, predicts one result
// for every datagram and compares each result transfer field by field.
// ============================================================================
module stunp_result_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    stunp_in_if         in_ch,
    stunp_out_if        out_ch,
    output int          outstanding,
    output int          failures
);
    timeunit 1ns;
    timeprecision 1ps;

    import stunp_pkg::*;

    localparam logic [POSITION_BITS_DEFAULT-1:0] POSITION_MAX = '1;
    localparam int unsigned PAD_MASK = ~32'd3;

    // One expected parse result per datagram.
    typedef struct packed {
        logic        header_complete;
        logic [15:0] message_type;
        logic        is_binding_request;
        logic        is_binding_indication;
        logic [31:0] tid_high;
        logic [63:0] tid_low;
        logic        found;
        logic [16:0] value_offset;
        logic [15:0] value_length;
    } parse_result_t;

    parse_result_t pending_results[$];
    int            fail_count;

    // Shadow copy of the per-datagram parse state and the search type.
    logic [15:0]                    search_type;
    logic [POSITION_BITS_DEFAULT-1:0] position;
    logic [15:0]                    decl_length;
    logic [15:0]                    msg_type;
    logic [31:0]                    cookie;
    logic [31:0]                    tid_hi;
    logic [63:0]                    tid_lo;
    logic [16:0]                    next_attr;
    logic [31:0]                    attr_header;
    bit                             walk_done;
    bit                             hit;
    logic [16:0]                    hit_offset;
    logic [15:0]                    hit_length;

    task automatic clear_datagram();
        position    = '0;
        decl_length = '0;
        msg_type    = '0;
        cookie      = '0;
        tid_hi      = '0;
        tid_lo      = '0;
        next_attr   = HEADER_BYTES;
        attr_header = '0;
        walk_done   = 1'b0;
        hit         = 1'b0;
        hit_offset  = '0;
        hit_length  = '0;
    endtask

    // Folds one byte into the shadow state; on the last byte it queues
    // the result the parser must produce for the datagram.
    task automatic parse_byte(input logic [7:0] b, input logic is_last);
        int unsigned   idx;
        int unsigned   start;
        int unsigned   msg_end;
        int unsigned   alen;
        int unsigned   count;
        logic [15:0]   atype;
        bit            complete;
        bit            cookie_ok;
        parse_result_t res;
        idx = position;
        if (idx < TYPE_END)
            msg_type = {msg_type[7:0], b};
        else if (idx < LENGTH_END)
            decl_length = {decl_length[7:0], b};
        else if (idx < COOKIE_END)
            cookie = {cookie[23:0], b};
        else if (idx < TIDH_END)
            tid_hi = {tid_hi[23:0], b};
        else if (idx < TIDL_END)
            tid_lo = {tid_lo[55:0], b};
        else if (!walk_done)
        begin
            start   = next_attr;
            msg_end = HEADER_BYTES + decl_length;
            if (idx >= start && idx <= start + 3)
                attr_header = {attr_header[23:0], b};
            // A full attribute header either ends the walk or moves past
            // the padded value to the next header.
            if (idx == start + 3)
            begin
                atype = attr_header[31:16];
                alen  = attr_header[15:0];
                if (start + 4 > msg_end || start + 4 + alen > msg_end)
                    walk_done = 1'b1;
                else if (atype == search_type)
                begin
                    walk_done  = 1'b1;
                    hit        = 1'b1;
                    hit_offset = 17'(start + 4);
                    hit_length = 16'(alen);
                end
                else
                    next_attr = 17'(start + 4 + ((alen + 3) & PAD_MASK));
            end
        end
        if (position != POSITION_MAX)
            position = position + 1'b1;
        if (is_last)
        begin
            count     = idx + 1;
            complete  = count >= HEADER_BYTES && HEADER_BYTES + decl_length <= count;
            cookie_ok = cookie == MAGIC_COOKIE;
            res.header_complete       = complete;
            res.message_type          = msg_type;
            res.is_binding_request    = complete && cookie_ok &&
                                        msg_type == TYPE_BINDING_REQUEST;
            res.is_binding_indication = complete && cookie_ok &&
                                        msg_type == TYPE_BINDING_INDICATION;
            res.tid_high              = tid_hi;
            res.tid_low               = tid_lo;
            res.found                 = complete && hit;
            res.value_offset          = res.found ? hit_offset : '0;
            res.value_length          = res.found ? hit_length : '0;
            pending_results.push_back(res);
            clear_datagram();
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    // Result transfers are matched before a new expectation is queued, so a
    // datagram finishing in the same cycle is never compared too early.
    always @(posedge clk or negedge rst_n)
    begin
        parse_result_t want;
        if (!rst_n)
        begin
            search_type = WANTED_TYPE_RESET;
            clear_datagram();
            pending_results.delete();
            fail_count  = 0;
            outstanding <= 0;
            failures    <= 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result transfer with no datagram outstanding");
                    fail_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("header_complete", want.header_complete,
                                out_ch.header_complete);
                    check_field("message_type", want.message_type, out_ch.message_type);
                    check_field("is_binding_request", want.is_binding_request,
                                out_ch.is_binding_request);
                    check_field("is_binding_indication", want.is_binding_indication,
                                out_ch.is_binding_indication);
                    check_field("tid_high", want.tid_high, out_ch.tid_high);
                    check_field("tid_low", want.tid_low, out_ch.tid_low);
                    check_field("found", want.found, out_ch.found);
                    check_field("value_offset", want.value_offset, out_ch.value_offset);
                    check_field("value_length", want.value_length, out_ch.value_length);
                end
            end
            if (cfg_we)
                search_type = cfg_wdata;
            if (in_ch.valid && in_ch.ready)
                parse_byte(in_ch.data_byte, in_ch.last);
            outstanding <= pending_results.size();
            failures    <= fail_count;
        end
    end

endmodule

FILE: tb/tb_stun_header_attribute_parser.sv
// ============================================================================
// STUN header and attribute parser testbench
// Feeds directed and random datagrams through the parser with bursty input
// and a stalling result receiver, reprograms the searched attribute type
// between phases and reports the verdict of the result checker.
// ============================================================================
module tb_stun_header_attribute_parser;
    timeunit 1ns;
    timeprecision 1ps;

    import stunp_pkg::*;

    localparam int          DRAIN_CYCLES    = 8;
    localparam int          HOLD_OFF_CYCLES = 400;
    localparam int          RANDOM_BYTES    = 420;
    localparam int          PHASES          = 6;
    localparam longint      LIMIT_NS        = 64'd60_000_000;
    localparam logic [15:0] ATTR_USERNAME   = 16'h0006;
    localparam logic [15:0] ATTR_SOFTWARE   = 16'h8022;
    localparam logic [15:0] TYPE_OTHER      = 16'h0101;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    int          outstanding;
    int          failures;

    logic [7:0]  msg_bytes[$];
    logic [15:0] wanted;
    int          burst_left;
    int          sent_bytes;
    int          sent_msgs;
    logic        flood;

    stunp_in_if  in_ch ();
    stunp_out_if out_ch ();

    stun_header_attribute_parser DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    stunp_result_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .outstanding (outstanding),
        .failures    (failures)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Datagram assembly helpers.
    task automatic put16(input logic [15:0] v);
        msg_bytes.push_back(v[15:8]);
        msg_bytes.push_back(v[7:0]);
    endtask

    task automatic put32(input logic [31:0] v);
        put16(v[31:16]);
        put16(v[15:0]);
    endtask

    task automatic put_header(input logic [15:0] mtype, input logic [15:0] len,
                              input logic [31:0] magic);
        put16(mtype);
        put16(len);
        put32(magic);
        put32($urandom);
        put32($urandom);
        put32($urandom);
    endtask

    task automatic put_attr(input logic [15:0] atype, input int len);
        put16(atype);
        put16(16'(len));
        repeat (len + ((4 - len % 4) % 4))
            msg_bytes.push_back(8'($urandom));
    endtask

    task automatic fill_to(input int n);
        while (msg_bytes.size() < n)
            msg_bytes.push_back(8'($urandom));
    endtask

    // Offers one byte; the sender runs in bursts with random gaps between.
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 4);
            if (gap > 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= b;
        in_ch.last      <= is_last;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        burst_left--;
    endtask

    task automatic send_msg();
        for (int i = 0; i < msg_bytes.size(); i++)
        begin
            send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
            sent_bytes++;
        end
        msg_bytes.delete();
        sent_msgs++;
    endtask

    // Waits until every datagram has been answered and the parser is idle.
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_wanted(input logic [15:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        wanted     = v;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Mostly well-formed messages with random content; the rest is noise or
    // messages with broken lengths, truncation or trailing bytes.
    task automatic send_random_msg(input bit tiny);
        int          choice;
        int          alen;
        int          total;
        logic [15:0] atype;
        logic [15:0] mtype;
        logic [15:0] dlen;
        logic [31:0] magic;
        choice = $urandom_range(0, 99);
        if (tiny)
            fill_to($urandom_range(1, 6));
        else if (choice < 15)
            fill_to($urandom_range(1, 48));
        else
        begin
            case ($urandom_range(0, 3))
                0:       mtype = TYPE_BINDING_REQUEST;
                1:       mtype = TYPE_BINDING_INDICATION;
                2:       mtype = TYPE_OTHER;
                default: mtype = 16'($urandom);
            endcase
            magic = ($urandom_range(0, 9) == 0) ? $urandom : MAGIC_COOKIE;
            put_header(mtype, 16'h0000, magic);
            repeat ($urandom_range(0, 4))
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: atype = wanted;
                    4, 5:       atype = $urandom_range(0, 1) ? ATTR_USERNAME : ATTR_SOFTWARE;
                    default:    atype = 16'($urandom);
                endcase
                alen = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                                   : $urandom_range(0, 12);
                if (choice >= 85 && $urandom_range(0, 3) == 0)
                begin
                    put16(atype);
                    put16(16'($urandom));
                    put32($urandom);
                end
                else
                    put_attr(atype, alen);
            end
            dlen = 16'(msg_bytes.size() - 20);
            if (choice >= 85)
            begin
                case ($urandom_range(0, 2))
                    0:       dlen = 16'($urandom_range(0, dlen + 8));
                    1:       dlen = 16'($urandom);
                    default: dlen = dlen | 16'd2;
                endcase
            end
            msg_bytes[2] = dlen[15:8];
            msg_bytes[3] = dlen[7:0];
            total = msg_bytes.size();
            case ($urandom_range(0, 9))
                0:       total = $urandom_range(1, total);
                1, 2:    total = total + $urandom_range(1, 12);
                default: ;
            endcase
            while (msg_bytes.size() > total)
                void'(msg_bytes.pop_back());
            fill_to(total);
        end
        send_msg();
    endtask

    // Stimulus and verdict.
    initial
    begin
        int          phase_bytes;
        int          phase_msgs;
        logic [15:0] v;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = '0;
        in_ch.valid     = 1'b0;
        in_ch.data_byte = '0;
        in_ch.last      = 1'b0;
        flood           = 1'b0;
        wanted          = WANTED_TYPE_RESET;
        burst_left      = 0;
        sent_bytes      = 0;
        sent_msgs       = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Short datagrams: one byte and one byte short of a header.
        msg_bytes.push_back(8'h00);
        send_msg();
        fill_to(19);
        send_msg();
        // Bare binding request and an indication with the wanted attribute.
        put_header(TYPE_BINDING_REQUEST, 16'd0, MAGIC_COOKIE);
        send_msg();
        put_header(TYPE_BINDING_INDICATION, 16'd8, MAGIC_COOKIE);
        put_attr(ATTR_USERNAME, 4);
        send_msg();
        // Skip a padded attribute, then find a padded one.
        put_header(TYPE_BINDING_REQUEST, 16'd20, MAGIC_COOKIE);
        put_attr(ATTR_SOFTWARE, 3);
        put_attr(ATTR_USERNAME, 5);
        send_msg();
        // Wanted attribute whose value overruns the message end.
        put_header(TYPE_BINDING_REQUEST, 16'd8, MAGIC_COOKIE);
        put16(ATTR_USERNAME);
        put16(16'd100);
        put32($urandom);
        send_msg();
        // Attribute header does not fit inside the declared length.
        put_header(TYPE_BINDING_REQUEST, 16'd2, MAGIC_COOKIE);
        put_attr(ATTR_USERNAME, 0);
        fill_to(26);
        send_msg();
        // Datagram shorter than the declared length.
        put_header(TYPE_BINDING_REQUEST, 16'd16, MAGIC_COOKIE);
        put_attr(ATTR_USERNAME, 8);
        send_msg();
        // Wanted attribute only in bytes past the declared length.
        put_header(TYPE_BINDING_REQUEST, 16'd0, MAGIC_COOKIE);
        put_attr(ATTR_USERNAME, 4);
        send_msg();
        // Wrong cookie, all ones, and a type that is neither binding code.
        put_header(TYPE_BINDING_REQUEST, 16'd0, 32'h2112_A443);
        send_msg();
        repeat (30) msg_bytes.push_back(8'hFF);
        send_msg();
        put_header(TYPE_OTHER, 16'd0, MAGIC_COOKIE);
        send_msg();
        // First of two matches wins; empty value; unpadded final value.
        put_header(TYPE_BINDING_INDICATION, 16'd16, MAGIC_COOKIE);
        put_attr(ATTR_USERNAME, 2);
        put_attr(ATTR_USERNAME, 4);
        send_msg();
        put_header(TYPE_BINDING_REQUEST, 16'd4, MAGIC_COOKIE);
        put_attr(ATTR_USERNAME, 0);
        send_msg();
        put_header(TYPE_BINDING_REQUEST, 16'd9, MAGIC_COOKIE);
        put_attr(ATTR_USERNAME, 5);
        send_msg();
        // Extreme search types.
        set_wanted(16'hFFFF);
        put_header(TYPE_BINDING_INDICATION, 16'd20, MAGIC_COOKIE);
        put_attr(TYPE_BINDING_REQUEST, 4);
        put_attr(16'hFFFF, 8);
        send_msg();
        set_wanted(16'h0000);
        put_header(TYPE_BINDING_REQUEST, 16'd4, MAGIC_COOKIE);
        put_attr(16'h0000, 0);
        send_msg();
        put_header(TYPE_BINDING_REQUEST, 16'd16, MAGIC_COOKIE);
        put_attr(ATTR_USERNAME, 4);
        put_attr(16'h0000, 4);
        send_msg();
        // Maximum declared length with a wanted attribute, in a datagram far
        // shorter than that length.
        set_wanted(ATTR_USERNAME);
        put_header(TYPE_BINDING_REQUEST, 16'hFFFF, MAGIC_COOKIE);
        put_attr(ATTR_USERNAME, 8);
        send_msg();

        // Random phases, each with its own search type.
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       v = 16'h0000;
                1:       v = 16'hFFFF;
                2:       v = ATTR_USERNAME;
                default: v = 16'($urandom);
            endcase
            set_wanted(v);
            phase_bytes = sent_bytes;
            phase_msgs  = sent_msgs;
            // A flood of tiny datagrams while the receiver holds off.
            if (p == 0)
            begin
                flood <= 1'b1;
                repeat (40) send_random_msg(1'b1);
            end
            while (sent_bytes - phase_bytes < RANDOM_BYTES / PHASES ||
                   sent_msgs - phase_msgs < 2)
                send_random_msg(1'b0);
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0 && outstanding == 0)
            $display("tb_stun_header_attribute_parser: clean");
        else
            $display("tb_stun_header_attribute_parser: errors");
        $finish;
    end

    // Result receiver: stall pattern in modes of random length, plus one
    // long hold-off when the flood of tiny datagrams starts.
    initial
    begin : receiver
        int mode;
        int mode_left;
        int stall_left;
        bit held;
        bit r;
        out_ch.ready = 1'b0;
        mode         = 0;
        mode_left    = 0;
        stall_left   = 0;
        held         = 1'b0;
        forever
        begin
            @(posedge clk);
            if (flood && !held)
            begin
                held = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(32, 256);
            end
            mode_left--;
            case (mode)
                0:       r = 1'b1;
                1:       r = $urandom_range(0, 1);
                2:       r = ($urandom_range(0, 3) == 0);
                default:
                begin
                    if (stall_left > 0)
                    begin
                        stall_left--;
                        r = 1'b0;
                    end
                    else
                    begin
                        r = 1'b1;
                        if ($urandom_range(0, 7) == 0)
                            stall_left = $urandom_range(1, 30);
                    end
                end
            endcase
            out_ch.ready <= r;
        end
    end

    initial
    begin
        #(LIMIT_NS);
        $display("tb_stun_header_attribute_parser: errors");
        $finish;
    end

endmodule
